// ----- src/spf_pkg.sv -----
`timescale 1ns / 1ps

package spf_pkg;

   // field and datapath widths
   localparam int RANGE_W = 16;
   localparam int COORD_W = 17;
   localparam int INDEX_W = 12;
   localparam int ANGLE_W = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int MUL_W = 18;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W = 36;
   // rotator: x and y in Q16 mm with gain growth, z at 32 bits per turn
   localparam int XY_W = 35;
   localparam int Z_W = 33;
   localparam int STAGE_W = 5;
   localparam int ATAN_LEN = 24;
   localparam int ATAN_W = 30;

   // constants
   localparam logic [RANGE_W-1:0] GAIN_Q16 = 16'd39797;
   localparam logic [COORD_W-1:0] COORD_LIMIT = 17'd65535;
   localparam logic [INDEX_W-1:0] INDEX_MAX = 12'd4095;

   localparam logic [RANGE_W-1:0] NEAR_THRESHOLD_RESET = 16'd1000;
   localparam logic [RANGE_W-1:0] MIN_SPACING_RESET = 16'd200;
   localparam logic [ANGLE_W-1:0] ANGLE_START_RESET = 16'd0;
   localparam logic [ANGLE_W-1:0] ANGLE_STEP_RESET = 16'd182;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_NEAR_THRESHOLD = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_SPACING = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE_START = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE_STEP = 8'd3;

   // arctangent of 2^-i in 1/2^32 turn
   localparam logic [ATAN_W-1:0] ATAN_TURN32 [ATAN_LEN] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
      30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
      30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
      30'd166886,    30'd83443,     30'd41721,     30'd20861,
      30'd10430,     30'd5215,      30'd2608,      30'd1304,
      30'd652,       30'd326,       30'd163,       30'd81
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_GAIN,
      ST_LOAD,
      ST_ROTATE,
      ST_ROUND,
      ST_DX,
      ST_DY,
      ST_SPACE,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } rot_ctrl_type;

   // Q16 to whole mm, round half up, saturate
   function automatic logic signed [COORD_W-1:0] q16_to_mm(input logic signed [XY_W-1:0] v);
      logic signed [XY_W-1:0] sum;
      logic signed [XY_W-17:0] whole;
      logic signed [COORD_W-1:0] res;
      sum = v + XY_W'(32768);
      whole = sum[XY_W-1:16];
      if (whole > $signed({2'b00, COORD_LIMIT})) begin
         res = $signed(COORD_LIMIT);
      end else if (whole < -$signed({2'b00, COORD_LIMIT})) begin
         res = -$signed(COORD_LIMIT);
      end else begin
         res = whole[COORD_W-1:0];
      end
      return res;
   endfunction

endpackage

// ----- src/spf_rotator.sv -----
`timescale 1ns / 1ps

module spf_rotator #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  spf_pkg::rot_ctrl_type               ctrl,
   input  logic signed [spf_pkg::XY_W-1:0]     x_init,
   input  logic signed [spf_pkg::Z_W-1:0]      z_init,
   output logic signed [spf_pkg::XY_W-1:0]     x_out,
   output logic signed [spf_pkg::XY_W-1:0]     y_out,
   output logic                                last_stage
);

   logic signed [spf_pkg::XY_W-1:0] x_ff, x_in;
   logic signed [spf_pkg::XY_W-1:0] y_ff, y_in;
   logic signed [spf_pkg::Z_W-1:0]  z_ff, z_in;
   logic [spf_pkg::STAGE_W-1:0]     stage_ff, stage_in;
   logic signed [spf_pkg::XY_W-1:0] x_shift;
   logic signed [spf_pkg::XY_W-1:0] y_shift;
   logic signed [spf_pkg::Z_W-1:0]  atan_step;

   // one micro-rotation per cycle while ctrl.step is high, through the shared shifter and adders
   always_comb begin
      x_shift = x_ff >>> stage_ff;
      y_shift = y_ff >>> stage_ff;
      atan_step = $signed({3'b000, spf_pkg::ATAN_TURN32[stage_ff]});
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      stage_in = stage_ff;
      if (ctrl.load) begin
         x_in = x_init;
         y_in = '0;
         z_in = z_init;
         stage_in = '0;
      end else if (ctrl.step) begin
         if (!z_ff[spf_pkg::Z_W-1]) begin
            x_in = x_ff - y_shift;
            y_in = y_ff + x_shift;
            z_in = z_ff - atan_step;
         end else begin
            x_in = x_ff + y_shift;
            y_in = y_ff - x_shift;
            z_in = z_ff + atan_step;
         end
         stage_in = stage_ff + 1'b1;
      end
   end

   // stage counter
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   // vector and angle registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign last_stage = (stage_ff == spf_pkg::STAGE_W'(CORDIC_STAGES - 1));

   // the table holds enough angles for every stage
   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |-> (stage_ff < spf_pkg::STAGE_W'(spf_pkg::ATAN_LEN)))
      else $error("rotator stage beyond arctangent table");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> (stage_ff == '0) && (y_ff == '0))
      else $error("rotator load did not restart the stage count");

endmodule

// ----- src/scan_point_spacing_filter.sv -----
// sequence: a near sample passes through ST_ANGLE, ST_GAIN, ST_LOAD, ST_ROTATE, ST_ROUND,
// ST_DX, ST_DY, ST_SPACE and ST_DECIDE, one micro-rotation per cycle in the shared rotator
// throughput: req_stall holds new samples until a near sample returns to idle, including any
// wait of a held point on rsp_stall; one per cycle for far samples (counter only)
// reset: synchronous, active high; registers return to their documented defaults,
// the beam counter and last point are cleared
`timescale 1ns / 1ps

module scan_point_spacing_filter #(
   parameter int MAX_BEAMS = 4096,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // sample channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [spf_pkg::RANGE_W-1:0]            req_range_mm,
   input  logic                                   req_scan_start,
   // point channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [spf_pkg::COORD_W-1:0]     rsp_point_x_mm,
   output logic signed [spf_pkg::COORD_W-1:0]     rsp_point_y_mm,
   output logic [spf_pkg::INDEX_W-1:0]            rsp_beam_index,
   // register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [spf_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [spf_pkg::RANGE_W-1:0]            csr_data
);

   localparam int BEAM_LIMIT_INT = (MAX_BEAMS < 4096) ? MAX_BEAMS - 1 : 4095;
   localparam logic [spf_pkg::INDEX_W-1:0] BEAM_LIMIT = spf_pkg::INDEX_W'(BEAM_LIMIT_INT);

   spf_pkg::state_type state_ff, state_in;

   logic [spf_pkg::RANGE_W-1:0] near_thr_ff;
   logic [spf_pkg::RANGE_W-1:0] spacing_ff;
   logic [spf_pkg::ANGLE_W-1:0] angle_start_ff;
   logic [spf_pkg::ANGLE_W-1:0] angle_step_ff;

   logic [spf_pkg::INDEX_W-1:0] sample_count_ff;
   logic                        have_last_ff;
   logic signed [spf_pkg::COORD_W-1:0] last_x_ff;
   logic signed [spf_pkg::COORD_W-1:0] last_y_ff;

   logic [spf_pkg::RANGE_W-1:0] range_ff;
   logic [spf_pkg::INDEX_W-1:0] idx_ff;
   logic                        negate_ff;
   logic signed [spf_pkg::Z_W-1:0] z_init_ff;
   logic signed [spf_pkg::COORD_W-1:0] px_ff;
   logic signed [spf_pkg::COORD_W-1:0] py_ff;
   logic [spf_pkg::ACC_W-1:0]   acc_ff;
   logic signed [spf_pkg::PROD_W-1:0] prod_ff;

   logic                        rsp_valid_ff;
   logic signed [spf_pkg::COORD_W-1:0] rsp_x_ff;
   logic signed [spf_pkg::COORD_W-1:0] rsp_y_ff;
   logic [spf_pkg::INDEX_W-1:0] rsp_idx_ff;

   logic                        req_accept;
   logic [spf_pkg::INDEX_W-1:0] cur_idx;
   logic                        near_hit;
   logic signed [spf_pkg::MUL_W-1:0] mul_a;
   logic signed [spf_pkg::MUL_W-1:0] mul_b;
   logic signed [spf_pkg::COORD_W:0] dx;
   logic signed [spf_pkg::COORD_W:0] dy;
   logic [spf_pkg::ANGLE_W-1:0] angle;
   logic signed [spf_pkg::ANGLE_W-1:0] angle_s;
   logic signed [spf_pkg::ANGLE_W:0] angle_fold;
   logic                        angle_wide;
   logic signed [spf_pkg::XY_W-1:0] x_init;
   logic signed [spf_pkg::XY_W-1:0] rot_x;
   logic signed [spf_pkg::XY_W-1:0] rot_y;
   logic                        rot_last;
   spf_pkg::rot_ctrl_type       rot_ctrl;
   logic                        emit;
   logic                        out_free;
   logic                        load_out;

   // handshake
   assign req_stall = (state_ff != spf_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign cur_idx = req_scan_start ? '0 : sample_count_ff;
   assign near_hit = (req_range_mm < near_thr_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         near_thr_ff <= spf_pkg::NEAR_THRESHOLD_RESET;
         spacing_ff <= spf_pkg::MIN_SPACING_RESET;
         angle_start_ff <= spf_pkg::ANGLE_START_RESET;
         angle_step_ff <= spf_pkg::ANGLE_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            spf_pkg::REG_NEAR_THRESHOLD: near_thr_ff <= csr_data;
            spf_pkg::REG_MIN_SPACING: spacing_ff <= csr_data;
            spf_pkg::REG_ANGLE_START: angle_start_ff <= csr_data;
            spf_pkg::REG_ANGLE_STEP: angle_step_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // beam angle fold into the right half plane
   always_comb begin
      angle = angle_start_ff + prod_ff[spf_pkg::ANGLE_W-1:0];
      angle_s = $signed(angle);
      angle_wide = (angle_s > 16'sd16384) || (angle_s < -16'sd16384);
      if (!angle_wide) begin
         angle_fold = {angle_s[spf_pkg::ANGLE_W-1], angle_s};
      end else if (angle_s > 16'sd0) begin
         angle_fold = {angle_s[spf_pkg::ANGLE_W-1], angle_s} - 17'sd32768;
      end else begin
         angle_fold = {angle_s[spf_pkg::ANGLE_W-1], angle_s} + 17'sd32768;
      end
   end

   assign x_init = negate_ff ? -prod_ff[spf_pkg::XY_W-1:0] : prod_ff[spf_pkg::XY_W-1:0];
   assign dx = {px_ff[spf_pkg::COORD_W-1], px_ff} - {last_x_ff[spf_pkg::COORD_W-1], last_x_ff};
   assign dy = {py_ff[spf_pkg::COORD_W-1], py_ff} - {last_y_ff[spf_pkg::COORD_W-1], last_y_ff};
   assign emit = !have_last_ff
      || (acc_ff > {{(spf_pkg::ACC_W-32){1'b0}}, prod_ff[31:0]});

   spf_rotator #(
      .CORDIC_STAGES(CORDIC_STAGES)
   ) u_rotator (
      .clock(clock),
      .reset(reset),
      .ctrl(rot_ctrl),
      .x_init(x_init),
      .z_init(z_init_ff),
      .x_out(rot_x),
      .y_out(rot_y),
      .last_stage(rot_last)
   );

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spf_pkg::ST_IDLE: begin
            if (req_accept && near_hit) state_in = spf_pkg::ST_ANGLE;
         end
         spf_pkg::ST_ANGLE: state_in = spf_pkg::ST_GAIN;
         spf_pkg::ST_GAIN: state_in = spf_pkg::ST_LOAD;
         spf_pkg::ST_LOAD: state_in = spf_pkg::ST_ROTATE;
         spf_pkg::ST_ROTATE: begin
            if (rot_last) state_in = spf_pkg::ST_ROUND;
         end
         spf_pkg::ST_ROUND: state_in = spf_pkg::ST_DX;
         spf_pkg::ST_DX: state_in = spf_pkg::ST_DY;
         spf_pkg::ST_DY: state_in = spf_pkg::ST_SPACE;
         spf_pkg::ST_SPACE: state_in = spf_pkg::ST_DECIDE;
         spf_pkg::ST_DECIDE: begin
            if (!emit || out_free) state_in = spf_pkg::ST_IDLE;
         end
         default: state_in = spf_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: multiplier operands and rotator control
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      rot_ctrl = '0;
      load_out = 1'b0;
      unique case (state_ff)
         spf_pkg::ST_ANGLE: begin
            mul_a = $signed({{(spf_pkg::MUL_W-spf_pkg::INDEX_W){1'b0}}, idx_ff});
            mul_b = $signed({{(spf_pkg::MUL_W-spf_pkg::ANGLE_W){1'b0}}, angle_step_ff});
         end
         spf_pkg::ST_GAIN: begin
            mul_a = $signed({{(spf_pkg::MUL_W-spf_pkg::RANGE_W){1'b0}}, range_ff});
            mul_b = $signed({{(spf_pkg::MUL_W-spf_pkg::RANGE_W){1'b0}}, spf_pkg::GAIN_Q16});
         end
         spf_pkg::ST_LOAD: rot_ctrl.load = 1'b1;
         spf_pkg::ST_ROTATE: rot_ctrl.step = 1'b1;
         spf_pkg::ST_DX: begin
            mul_a = dx;
            mul_b = dx;
         end
         spf_pkg::ST_DY: begin
            mul_a = dy;
            mul_b = dy;
         end
         spf_pkg::ST_SPACE, spf_pkg::ST_DECIDE: begin
            mul_a = $signed({{(spf_pkg::MUL_W-spf_pkg::RANGE_W){1'b0}}, spacing_ff});
            mul_b = $signed({{(spf_pkg::MUL_W-spf_pkg::RANGE_W){1'b0}}, spacing_ff});
            load_out = (state_ff == spf_pkg::ST_DECIDE) && emit && out_free;
         end
         default: ;
      endcase
   end

   // state and scan tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spf_pkg::ST_IDLE;
         sample_count_ff <= '0;
         have_last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_accept) begin
            sample_count_ff <= (cur_idx < BEAM_LIMIT) ? cur_idx + 1'b1 : cur_idx;
            if (req_scan_start) have_last_ff <= 1'b0;
         end
         if (load_out) have_last_ff <= 1'b1;
      end
   end

   // shared multiplier with registered product
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         range_ff <= req_range_mm;
         idx_ff <= cur_idx;
      end
      if (state_ff == spf_pkg::ST_GAIN) begin
         negate_ff <= angle_wide;
         z_init_ff <= {angle_fold, 16'b0};
      end
      if (state_ff == spf_pkg::ST_ROUND) begin
         px_ff <= spf_pkg::q16_to_mm(rot_x);
         py_ff <= spf_pkg::q16_to_mm(rot_y);
      end
      if (state_ff == spf_pkg::ST_DY) acc_ff <= prod_ff[spf_pkg::ACC_W-1:0];
      if (state_ff == spf_pkg::ST_SPACE) acc_ff <= acc_ff + prod_ff[spf_pkg::ACC_W-1:0];
      if (load_out) begin
         last_x_ff <= px_ff;
         last_y_ff <= py_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_x_ff <= px_ff;
         rsp_y_ff <= py_ff;
         rsp_idx_ff <= idx_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_point_x_mm = rsp_x_ff;
   assign rsp_point_y_mm = rsp_y_ff;
   assign rsp_beam_index = rsp_idx_ff;

   a_emit_sets_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> have_last_ff)
      else $error("point emitted without recording it as last point");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      sample_count_ff <= BEAM_LIMIT)
      else $error("beam counter beyond its limit");

   a_coord_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_x_ff != {1'b1, {(spf_pkg::COORD_W-1){1'b0}}})
         && (rsp_y_ff != {1'b1, {(spf_pkg::COORD_W-1){1'b0}}}))
      else $error("coordinate outside saturation range");

   a_far_no_work: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !near_hit) |=> (state_ff == spf_pkg::ST_IDLE))
      else $error("far sample started the rotator");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> out_free)
      else $error("output register overwritten while held");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// one emitted obstacle point
typedef struct {
   logic signed [spf_pkg::COORD_W-1:0] x;
   logic signed [spf_pkg::COORD_W-1:0] y;
   logic [spf_pkg::INDEX_W-1:0]        beam;
} obstacle_point_type;

// tracks register values and scan state, predicts the points and checks them
class spacing_scoreboard;
   localparam int     STAGES    = 16;
   localparam longint ROT_GAIN  = 39797;
   localparam longint COORD_MAX = 65535;
   localparam longint HALF_TURN = 32768;
   localparam longint QUARTER   = 16384;
   localparam longint ROUND_BIT = 32768;

   logic [spf_pkg::RANGE_W-1:0] near_threshold;
   logic [spf_pkg::RANGE_W-1:0] min_spacing;
   logic [spf_pkg::ANGLE_W-1:0] angle_start;
   logic [spf_pkg::ANGLE_W-1:0] angle_step;
   logic [spf_pkg::INDEX_W-1:0] beam_count;
   bit                          have_last;
   longint                      last_x;
   longint                      last_y;
   longint                      arc_turn [24];
   obstacle_point_type          expected_points [$];
   int                          errors;

   function new();
      // arctangent of 2^-i, 2^32 units per turn
      arc_turn = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772,
                   166886, 83443, 41721, 20861, 10430, 5215,
                   2608, 1304, 652, 326, 163, 81};
      near_threshold = spf_pkg::NEAR_THRESHOLD_RESET;
      min_spacing = spf_pkg::MIN_SPACING_RESET;
      angle_start = spf_pkg::ANGLE_START_RESET;
      angle_step = spf_pkg::ANGLE_STEP_RESET;
      beam_count = '0;
      have_last = 1'b0;
      last_x = 0;
      last_y = 0;
      errors = 0;
   endfunction

   function int pending();
      return expected_points.size();
   endfunction

   function void write_register(logic [spf_pkg::CSR_INDEX_W-1:0] index,
                                logic [spf_pkg::RANGE_W-1:0] data);
      case (index)
         spf_pkg::REG_NEAR_THRESHOLD: near_threshold = data;
         spf_pkg::REG_MIN_SPACING: min_spacing = data;
         spf_pkg::REG_ANGLE_START: angle_start = data;
         spf_pkg::REG_ANGLE_STEP: angle_step = data;
         default: ;
      endcase
   endfunction

   // Q16 to whole mm, half up, clamped
   function longint to_mm(longint v);
      longint r;
      r = (v + ROUND_BIT) >>> 16;
      if (r > COORD_MAX) r = COORD_MAX;
      if (r < -COORD_MAX) r = -COORD_MAX;
      return r;
   endfunction

   // iterative rotation of (range * gain, 0) by the beam angle
   function void rotate(logic [spf_pkg::RANGE_W-1:0] range,
                        logic [spf_pkg::ANGLE_W-1:0] angle,
                        output longint px, output longint py);
      longint a, x, y, z, xs, ys;
      a = longint'(angle);
      if (a >= HALF_TURN) a -= 2 * HALF_TURN;
      x = longint'(range) * ROT_GAIN;
      y = 0;
      // beyond a quarter turn: flip the vector and fold the angle
      if (a > QUARTER || a < -QUARTER) begin
         x = -x;
         a = (a > 0) ? a - HALF_TURN : a + HALF_TURN;
      end
      z = a * 65536;
      for (int i = 0; i < STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= arc_turn[i];
         end else begin
            x += ys;
            y -= xs;
            z += arc_turn[i];
         end
      end
      px = to_mm(x);
      py = to_mm(y);
   endfunction

   function void note_sample(logic [spf_pkg::RANGE_W-1:0] range, logic start);
      logic [spf_pkg::INDEX_W-1:0] idx;
      logic [spf_pkg::ANGLE_W-1:0] angle;
      longint x, y, dx, dy;
      bit emit;
      obstacle_point_type p;
      if (start) begin
         beam_count = '0;
         have_last = 1'b0;
      end
      idx = beam_count;
      if (beam_count < spf_pkg::INDEX_MAX) beam_count++;
      if (range >= near_threshold) return;
      angle = angle_start + 16'(idx * angle_step);
      rotate(range, angle, x, y);
      // spacing filter against the last emitted point
      if (have_last) begin
         dx = x - last_x;
         dy = y - last_y;
         emit = (dx * dx + dy * dy) > longint'(min_spacing) * longint'(min_spacing);
      end else begin
         emit = 1'b1;
      end
      if (!emit) return;
      have_last = 1'b1;
      last_x = x;
      last_y = y;
      p.x = 17'(x);
      p.y = 17'(y);
      p.beam = idx;
      expected_points = {expected_points, p};
   endfunction

   function void check_point(logic signed [spf_pkg::COORD_W-1:0] x,
                             logic signed [spf_pkg::COORD_W-1:0] y,
                             logic [spf_pkg::INDEX_W-1:0] beam);
      obstacle_point_type want;
      if (expected_points.size() == 0) begin
         $display("%0t: unexpected point (%0d, %0d) beam %0d", $time, x, y, beam);
         errors++;
         return;
      end
      want = expected_points.pop_front();
      if (want.x !== x || want.y !== y || want.beam !== beam) begin
         $display("%0t: point mismatch, expected (%0d, %0d) beam %0d, got (%0d, %0d) beam %0d",
                  $time, want.x, want.y, want.beam, x, y, beam);
         errors++;
      end
   endfunction
endclass

module tb;

   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_SAMPLES = 950;
   localparam int MAX_GAP = 11;
   localparam logic [spf_pkg::RANGE_W-1:0] NO_RETURN = 16'hFFFF;
   localparam logic [spf_pkg::RANGE_W-1:0] FULL_SCALE = 16'hFFFF;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [spf_pkg::RANGE_W-1:0] req_range_mm;
   logic req_scan_start;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [spf_pkg::COORD_W-1:0] rsp_point_x_mm;
   logic signed [spf_pkg::COORD_W-1:0] rsp_point_y_mm;
   logic [spf_pkg::INDEX_W-1:0] rsp_beam_index;
   logic csr_valid;
   logic csr_ready;
   logic [spf_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [spf_pkg::RANGE_W-1:0] csr_data;

   spacing_scoreboard board = new();
   bit send_burst;
   bit recv_burst;
   logic [spf_pkg::RANGE_W-1:0] cur_threshold;
   int cycle_count;

   scan_point_spacing_filter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_range_mm(req_range_mm),
      .req_scan_start(req_scan_start),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_point_x_mm(rsp_point_x_mm),
      .rsp_point_y_mm(rsp_point_y_mm),
      .rsp_beam_index(rsp_beam_index),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int draw_gap(bit burst);
      return burst ? 0 : int'($urandom_range(0, MAX_GAP));
   endfunction

   // transaction monitor and run limit
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_register(csr_index, csr_data);
         if (req_valid && !req_stall) board.note_sample(req_range_mm, req_scan_start);
         if (rsp_valid && !rsp_stall) begin
            board.check_point(rsp_point_x_mm, rsp_point_y_mm, rsp_beam_index);
         end
      end
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // point receiver with random stalls
   initial begin
      int wait_cycles;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         wait_cycles = draw_gap(recv_burst);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // one sample transaction; valid stays high for a back-to-back follower
   task automatic send_sample(input logic [spf_pkg::RANGE_W-1:0] range, input logic start);
      int gap;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_range_mm <= range;
      req_scan_start <= start;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic set_register(input logic [spf_pkg::CSR_INDEX_W-1:0] index,
                               input logic [spf_pkg::RANGE_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // wait for all points, then for any dropped near sample still in flight
   task automatic settle();
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [spf_pkg::RANGE_W-1:0] thr,
                                input logic [spf_pkg::RANGE_W-1:0] spacing,
                                input logic [spf_pkg::ANGLE_W-1:0] start,
                                input logic [spf_pkg::ANGLE_W-1:0] step,
                                input bit add_spare);
      logic [spf_pkg::CSR_INDEX_W-1:0] spare;
      settle();
      set_register(spf_pkg::REG_NEAR_THRESHOLD, thr);
      set_register(spf_pkg::REG_MIN_SPACING, spacing);
      set_register(spf_pkg::REG_ANGLE_START, start);
      set_register(spf_pkg::REG_ANGLE_STEP, step);
      // write to an unmapped index, must change nothing
      if (add_spare) begin
         spare = spf_pkg::CSR_INDEX_W'($urandom_range(int'(spf_pkg::REG_ANGLE_STEP) + 1,
                                                      (1 << spf_pkg::CSR_INDEX_W) - 1));
         set_register(spare, spf_pkg::RANGE_W'($urandom));
      end
      csr_valid <= 1'b0;
      cur_threshold = thr;
   endtask

   // mostly near returns, some close to the previous range, some far or missing
   function automatic logic [spf_pkg::RANGE_W-1:0] pick_range(
         logic [spf_pkg::RANGE_W-1:0] prev);
      int d;
      case ($urandom_range(0, 9))
         0: return NO_RETURN;
         1: return spf_pkg::RANGE_W'($urandom);
         2, 3: begin
            d = int'(prev) + int'($urandom_range(0, 100)) - 50;
            if (d < 0) d = 0;
            if (d > int'(FULL_SCALE)) d = int'(FULL_SCALE);
            return spf_pkg::RANGE_W'(d);
         end
         default: begin
            if (cur_threshold == 0) return '0;
            return spf_pkg::RANGE_W'($urandom_range(0, int'(cur_threshold) - 1));
         end
      endcase
   endfunction

   // stimulus
   initial begin
      int random_count;
      int n_scans;
      int scan_len;
      logic start;
      logic [spf_pkg::RANGE_W-1:0] range;
      logic [spf_pkg::RANGE_W-1:0] prev;
      logic [spf_pkg::RANGE_W-1:0] thr;
      logic [spf_pkg::RANGE_W-1:0] spacing;
      logic [spf_pkg::ANGLE_W-1:0] a_start;
      logic [spf_pkg::ANGLE_W-1:0] a_step;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_range_mm <= '0;
      req_scan_start <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      send_burst = 1'b0;
      recv_burst = 1'b0;
      cur_threshold = spf_pkg::NEAR_THRESHOLD_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: threshold edge, no return, restart mid-scan
      send_sample(16'd999, 1'b1);
      send_sample(16'd1000, 1'b0);
      send_sample(16'd0, 1'b0);
      send_sample(NO_RETURN, 1'b0);
      send_sample(16'd600, 1'b1);
      req_valid <= 1'b0;

      // quarter-turn steps, zero spacing drops a repeated point
      apply_setting(FULL_SCALE, 16'd0, 16'd0, 16'd16384, 1'b1);
      send_sample(16'd0, 1'b1);
      send_sample(16'd0, 1'b0);
      send_sample(16'd65534, 1'b0);
      send_sample(16'd65534, 1'b0);
      send_sample(NO_RETURN, 1'b0);
      send_sample(16'd12345, 1'b0);
      req_valid <= 1'b0;

      // zero threshold: nothing is near
      apply_setting(16'd0, FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b0);
      send_sample(16'd0, 1'b1);
      send_sample(NO_RETURN, 1'b0);
      req_valid <= 1'b0;

      // widest spacing, angles just under a full turn
      apply_setting(16'd40000, FULL_SCALE, FULL_SCALE, FULL_SCALE, 1'b1);
      send_sample(16'd30000, 1'b1);
      send_sample(16'd30000, 1'b0);
      send_sample(16'd39999, 1'b0);
      req_valid <= 1'b0;

      // random phases of scans
      random_count = 0;
      prev = '0;
      while (random_count < RANDOM_SAMPLES) begin
         case ($urandom_range(0, 7))
            0: thr = '0;
            1: thr = FULL_SCALE;
            2, 3: thr = spf_pkg::RANGE_W'($urandom);
            default: thr = spf_pkg::RANGE_W'($urandom_range(100, 5000));
         endcase
         case ($urandom_range(0, 5))
            0: spacing = '0;
            1: spacing = FULL_SCALE;
            2: spacing = spf_pkg::RANGE_W'($urandom);
            default: spacing = spf_pkg::RANGE_W'($urandom_range(0, 1500));
         endcase
         case ($urandom_range(0, 3))
            0: a_start = '0;
            1: a_start = FULL_SCALE;
            default: a_start = spf_pkg::ANGLE_W'($urandom);
         endcase
         case ($urandom_range(0, 5))
            0: a_step = '0;
            1: a_step = FULL_SCALE;
            2: a_step = spf_pkg::ANGLE_W'($urandom);
            default: a_step = spf_pkg::ANGLE_W'($urandom_range(1, 800));
         endcase
         apply_setting(thr, spacing, a_start, a_step, $urandom_range(0, 1) == 0);
         send_burst = ($urandom_range(0, 3) == 0);
         recv_burst = ($urandom_range(0, 3) == 0);

         n_scans = $urandom_range(1, 4);
         for (int s = 0; s < n_scans; s++) begin
            scan_len = $urandom_range(4, 60);
            for (int k = 0; k < scan_len; k++) begin
               // occasionally a scan runs on without its start flag, or restarts early
               start = (k == 0 && $urandom_range(0, 7) != 0) || ($urandom_range(0, 39) == 0);
               range = pick_range(prev);
               prev = range;
               send_sample(range, start);
               random_count++;
            end
         end
         req_valid <= 1'b0;
      end

      // drain and report
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- scan_point_spacing_filter.f -----
src/spf_pkg.sv
src/spf_rotator.sv
src/scan_point_spacing_filter.sv
tb/tb.sv
